@@ sv/sdspi_pkg.sv @@
// Shared types and constants for the SPI-mode SD card sequencer.
// Used by sdspi_core and sd_spi_init_and_block_read; no dependencies.
package sdspi_pkg;

   // Bytes in one data block (sector); also the CMD16 argument.
   localparam int BLOCK_BYTES = 512;
   // Data counter must hold BLOCK_BYTES itself.
   localparam int DATA_W = $clog2(BLOCK_BYTES + 1);

   // Request kinds
   localparam logic [1:0] KIND_START_INIT = 2'd0;
   localparam logic [1:0] KIND_START_READ = 2'd1;
   localparam logic [1:0] KIND_SLOT_DONE  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_BUSY      = 2'd0;
   localparam logic [1:0] STATUS_IDLE      = 2'd1;
   localparam logic [1:0] STATUS_INIT_DONE = 2'd2;
   localparam logic [1:0] STATUS_READ_DONE = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] REG_RESPONSE_POLL_LIMIT = 2'd0;
   localparam logic [1:0] REG_COMMAND_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] REG_TOKEN_POLL_LIMIT    = 2'd2;
   localparam logic [1:0] REG_IDLE_CLOCK_BYTES    = 2'd3;

   // Card commands and fixed bytes
   localparam logic [7:0] CMD_GO_IDLE     = 8'h40;
   localparam logic [7:0] CMD_SEND_OP     = 8'h41;
   localparam logic [7:0] CMD_SET_BLOCKLEN = 8'h50;
   localparam logic [7:0] CMD_READ_SINGLE = 8'h51;
   localparam logic [7:0] CRC_GO_IDLE     = 8'h95;
   localparam logic [7:0] CRC_SEND_OP     = 8'hF9;
   localparam logic [7:0] BYTE_IDLE       = 8'hFF;
   localparam logic [7:0] TOKEN_START     = 8'hFE;
   localparam logic [7:0] R1_IDLE_STATE   = 8'h01;
   localparam logic [7:0] R1_READY        = 8'h00;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CLOCKS,
      PH_FRAME,
      PH_R1,
      PH_TAIL,
      PH_TOKEN,
      PH_DATA,
      PH_TRAILER
   } phase_type;

   typedef struct packed {
      logic       slot_request;
      logic [7:0] mosi_byte;
      logic       card_deselect;
      logic       read_valid;
      logic [7:0] read_byte;
      logic [1:0] status;
      logic       timed_out;
      logic [7:0] last_response;
   } rsp_type;

endpackage

@@ sv/sd_spi_init_and_block_read.sv @@
// Top level of the SPI-mode SD card init and block read sequencer.
// Holds the request and result registers; depends on sdspi_pkg, sdspi_core.
//
// Usage:
//  - req_ channel: one transfer per SPI byte slot event. Kind START_INIT
//    or START_READ (with req_sector) begins a sequence while idle; kind
//    SLOT_DONE hands back the MISO byte of the slot just exchanged.
//  - rsp_ channel: exactly one transfer per request. It names the next
//    slot (rsp_slot_request, rsp_mosi_byte, rsp_card_deselect), a sector
//    data byte when rsp_read_valid, plus status, timeout flag and last R1.
//  - csr_ port: plain register writes, only while no transfer is in
//    flight (both registers empty).
//  - Path: a request passes the request register, then the result register;
//    rsp_stall can hold it in either.
//  - Throughput: one transfer per cycle while rsp_stall is low; the single-pass next-state logic
//    in sdspi_core is the only work between the two registers. In system
//    use each slot event follows an 8-bit SPI exchange.
//  - rsp_stall holds the result register; the request register then
//    fills and req_stall rises until the result moves on.
//  - Reset (synchronous): sequencer idle, limits at default values,
//    both registers empty.
module sd_spi_init_and_block_read (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [22:0] req_sector,
   input  logic [7:0]  req_miso_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_slot_request,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_card_deselect,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic [1:0]  rsp_status,
   output logic        rsp_timed_out,
   output logic [7:0]  rsp_last_response
);
   import sdspi_pkg::*;

   // request register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_kind_ff;
   logic [22:0] in_sector_ff;
   logic [7:0]  in_miso_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;
   rsp_type     core_result;

   logic out_ready;   // result register can take a new transfer
   logic advance;     // request register moves into the sequencer
   logic accept;      // request transfer this cycle

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payloads, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff   <= req_kind;
         in_sector_ff <= req_sector;
         in_miso_ff   <= req_miso_byte;
      end
      if (advance)
         out_ff <= core_result;
   end

   sdspi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (advance),
      .kind      (in_kind_ff),
      .sector    (in_sector_ff),
      .miso_byte (in_miso_ff),
      .result    (core_result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_slot_request  = out_ff.slot_request;
   assign rsp_mosi_byte     = out_ff.mosi_byte;
   assign rsp_card_deselect = out_ff.card_deselect;
   assign rsp_read_valid    = out_ff.read_valid;
   assign rsp_read_byte     = out_ff.read_byte;
   assign rsp_status        = out_ff.status;
   assign rsp_timed_out     = out_ff.timed_out;
   assign rsp_last_response = out_ff.last_response;

   // a slot is requested exactly while the sequencer reports busy
   a_busy_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot_request == (rsp_status == STATUS_BUSY)))
      else $error("slot request and busy status disagree");

   // a data byte always leaves more slots to run
   a_data_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_slot_request)
      else $error("data byte without a following slot");

   // nothing reaches the result register without a held request
   a_adv_src: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff && !(out_valid_ff && rsp_stall) |=> !rsp_valid)
      else $error("result without a request");

endmodule

@@ sv/sdspi_core.sv @@
// Sequencer state, configuration registers and per-slot next-state logic.
// Depends on sdspi_pkg.
module sdspi_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                step,
   input  logic [1:0]          kind,
   input  logic [22:0]         sector,
   input  logic [7:0]          miso_byte,
   output sdspi_pkg::rsp_type  result
);
   import sdspi_pkg::*;

   // configuration
   logic [7:0]  rpl_ff;
   logic [15:0] crl_ff;
   logic [15:0] tpl_ff;
   logic [7:0]  icb_ff;
   logic [7:0]  rpl_eff;
   logic [15:0] crl_eff;
   logic [15:0] tpl_eff;
   logic [7:0]  icb_eff;

   // sequencer state
   phase_type         phase_ff, phase_in;
   logic [3:0]        pos_ff, pos_in, pos_inc;
   logic [7:0]        cmd_ff, cmd_in;
   logic [31:0]       arg_ff, arg_in;
   logic              keep_ff, keep_in;
   logic [15:0]       retry_ff, retry_in, retry_inc;
   logic [15:0]       poll_ff, poll_in, poll_inc;
   logic [DATA_W-1:0] data_ff, data_in, data_inc;
   logic              tmo_ff, tmo_in;
   logic [7:0]        resp_ff, resp_in;

   logic [1:0]  done_code;
   logic        rvalid;
   logic [7:0]  rbyte;
   logic        r1_ok;
   logic [31:0] read_arg;

   assign rpl_eff = (rpl_ff == 8'd0)  ? 8'd1  : rpl_ff;
   assign crl_eff = (crl_ff == 16'd0) ? 16'd1 : crl_ff;
   assign tpl_eff = (tpl_ff == 16'd0) ? 16'd1 : tpl_ff;
   assign icb_eff = (icb_ff == 8'd0)  ? 8'd1  : icb_ff;

   assign pos_inc   = pos_ff + 4'd1;
   assign retry_inc = retry_ff + 16'd1;
   assign poll_inc  = poll_ff + 16'd1;
   assign data_inc  = data_ff + DATA_W'(1);

   // byte address; sector * BLOCK_BYTES always fits in 32 bits
   assign read_arg = 32'({9'd0, sector} * 32'(BLOCK_BYTES));

   assign r1_ok = (cmd_ff == CMD_GO_IDLE) ? (resp_ff == R1_IDLE_STATE)
                                          : (resp_ff == R1_READY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rpl_ff <= 8'd8;
         crl_ff <= 16'hFFFF;
         tpl_ff <= 16'hFFFF;
         icb_ff <= 8'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_RESPONSE_POLL_LIMIT: rpl_ff <= csr_data[7:0];
            REG_COMMAND_RETRY_LIMIT: crl_ff <= csr_data;
            REG_TOKEN_POLL_LIMIT:    tpl_ff <= csr_data;
            REG_IDLE_CLOCK_BYTES:    icb_ff <= csr_data[7:0];
            default:                 rpl_ff <= rpl_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      cmd_in    = cmd_ff;
      arg_in    = arg_ff;
      keep_in   = keep_ff;
      retry_in  = retry_ff;
      poll_in   = poll_ff;
      data_in   = data_ff;
      tmo_in    = tmo_ff;
      resp_in   = resp_ff;
      done_code = STATUS_BUSY;
      rvalid    = 1'b0;
      rbyte     = 8'd0;
      if (phase_ff == PH_IDLE) begin
         if (kind == KIND_START_INIT) begin
            tmo_in   = 1'b0;
            retry_in = 16'd0;
            poll_in  = 16'd0;
            phase_in = PH_CLOCKS;
         end else if (kind == KIND_START_READ) begin
            tmo_in   = 1'b0;
            retry_in = 16'd0;
            cmd_in   = CMD_READ_SINGLE;
            arg_in   = read_arg;
            keep_in  = 1'b1;
            pos_in   = 4'd0;
            phase_in = PH_FRAME;
         end
      end else if (kind == KIND_SLOT_DONE) begin
         unique case (phase_ff)
            PH_CLOCKS: begin
               poll_in = poll_inc;
               if (poll_inc >= {8'd0, icb_eff}) begin
                  retry_in = 16'd0;
                  cmd_in   = CMD_GO_IDLE;
                  arg_in   = 32'd0;
                  keep_in  = 1'b0;
                  pos_in   = 4'd0;
                  phase_in = PH_FRAME;
               end
            end
            PH_FRAME: begin
               pos_in = pos_inc;
               if (pos_inc >= 4'd9) begin
                  phase_in = PH_R1;
                  poll_in  = 16'd0;
               end
            end
            PH_R1: begin
               resp_in = miso_byte;
               poll_in = poll_inc;
               if (!miso_byte[7]) begin
                  phase_in = PH_TAIL;
                  pos_in   = 4'd0;
               end else if (poll_inc >= {8'd0, rpl_eff}) begin
                  tmo_in   = 1'b1;
                  phase_in = PH_TAIL;
                  pos_in   = 4'd0;
               end
            end
            PH_TAIL: begin
               pos_in = pos_inc;
               if ((keep_ff && pos_inc >= 4'd1) || pos_inc >= 4'd4) begin
                  if (cmd_ff == CMD_READ_SINGLE) begin
                     phase_in = PH_TOKEN;
                     poll_in  = 16'd0;
                  end else if (!r1_ok && retry_inc < crl_eff) begin
                     // retry same command
                     retry_in = retry_inc;
                     keep_in  = 1'b0;
                     pos_in   = 4'd0;
                     phase_in = PH_FRAME;
                  end else begin
                     if (!r1_ok) tmo_in = 1'b1;
                     retry_in = 16'd0;
                     keep_in  = 1'b0;
                     pos_in   = 4'd0;
                     if (cmd_ff == CMD_GO_IDLE) begin
                        cmd_in   = CMD_SEND_OP;
                        arg_in   = 32'd0;
                        phase_in = PH_FRAME;
                     end else if (cmd_ff == CMD_SEND_OP) begin
                        cmd_in   = CMD_SET_BLOCKLEN;
                        arg_in   = 32'(BLOCK_BYTES);
                        phase_in = PH_FRAME;
                     end else begin
                        pos_in    = pos_inc;
                        keep_in   = keep_ff;
                        phase_in  = PH_IDLE;
                        done_code = STATUS_INIT_DONE;
                     end
                  end
               end
            end
            PH_TOKEN: begin
               poll_in = poll_inc;
               if (miso_byte == TOKEN_START) begin
                  phase_in = PH_DATA;
                  data_in  = '0;
               end else if (poll_inc >= tpl_eff) begin
                  tmo_in   = 1'b1;
                  phase_in = PH_DATA;
                  data_in  = '0;
               end
            end
            PH_DATA: begin
               rvalid  = 1'b1;
               rbyte   = miso_byte;
               data_in = data_inc;
               if (data_inc >= DATA_W'(BLOCK_BYTES)) begin
                  phase_in = PH_TRAILER;
                  pos_in   = 4'd0;
               end
            end
            PH_TRAILER: begin
               pos_in = pos_inc;
               if (pos_inc >= 4'd6) begin
                  phase_in  = PH_IDLE;
                  done_code = STATUS_READ_DONE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // result for this slot, taken from the updated state
   always_comb begin
      result.read_valid    = rvalid;
      result.read_byte     = rbyte;
      result.timed_out     = tmo_in;
      result.last_response = resp_in;
      result.mosi_byte     = BYTE_IDLE;
      result.card_deselect = 1'b0;
      if (phase_in == PH_IDLE) begin
         result.slot_request  = 1'b0;
         result.card_deselect = 1'b1;
         result.status = (done_code != STATUS_BUSY) ? done_code : STATUS_IDLE;
      end else begin
         result.slot_request = 1'b1;
         result.status       = STATUS_BUSY;
         unique case (phase_in)
            PH_CLOCKS:  result.card_deselect = 1'b1;
            PH_FRAME: begin
               unique case (pos_in)
                  4'd3:    result.mosi_byte = cmd_in;
                  4'd4:    result.mosi_byte = arg_in[31:24];
                  4'd5:    result.mosi_byte = arg_in[23:16];
                  4'd6:    result.mosi_byte = arg_in[15:8];
                  4'd7:    result.mosi_byte = arg_in[7:0];
                  4'd8: begin
                     if (cmd_in == CMD_GO_IDLE)
                        result.mosi_byte = CRC_GO_IDLE;
                     else if (cmd_in == CMD_SEND_OP)
                        result.mosi_byte = CRC_SEND_OP;
                     else
                        result.mosi_byte = BYTE_IDLE;
                  end
                  default: result.mosi_byte = BYTE_IDLE;
               endcase
            end
            PH_TAIL:    result.card_deselect = (pos_in >= 4'd1);
            PH_TRAILER: result.card_deselect = (pos_in >= 4'd3);
            default:    result.card_deselect = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 4'd0;
         cmd_ff   <= 8'd0;
         arg_ff   <= 32'd0;
         keep_ff  <= 1'b0;
         retry_ff <= 16'd0;
         poll_ff  <= 16'd0;
         data_ff  <= '0;
         tmo_ff   <= 1'b0;
         resp_ff  <= 8'hFF;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cmd_ff   <= cmd_in;
         arg_ff   <= arg_in;
         keep_ff  <= keep_in;
         retry_ff <= retry_in;
         poll_ff  <= poll_in;
         data_ff  <= data_in;
         tmo_ff   <= tmo_in;
         resp_ff  <= resp_in;
      end
   end

   // frame never runs past the CRC byte
   a_frame_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FRAME |-> pos_ff <= 4'd8)
      else $error("frame position beyond CRC byte");

   // data counter stays inside the block
   a_data_cnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> data_ff < DATA_W'(BLOCK_BYTES))
      else $error("data count beyond block size");

   // tail position stays at three or below
   a_tail_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TAIL |-> pos_ff <= 4'd3)
      else $error("tail position out of range");

endmodule

@@ tb/sv/sdspi_slot_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the SPI-mode SD sequencer: tracks csr writes and
// request transfers, predicts each result and compares it. Uses sdspi_pkg.
module sdspi_slot_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [22:0] req_sector,
   input  logic [7:0]  req_miso_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_slot_request,
   input  logic [7:0]  rsp_mosi_byte,
   input  logic        rsp_card_deselect,
   input  logic        rsp_read_valid,
   input  logic [7:0]  rsp_read_byte,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_timed_out,
   input  logic [7:0]  rsp_last_response,
   output int          fail_count,
   output int          pending_count
);
   import sdspi_pkg::*;

   // limits
   logic [7:0]  resp_poll_lim;
   logic [15:0] retry_lim;
   logic [15:0] token_poll_lim;
   logic [7:0]  idle_clk_bytes;

   // sequencer state
   phase_type   seq_phase;
   logic [3:0]  frame_pos;
   logic [7:0]  cmd_byte;
   logic [31:0] cmd_arg;
   logic        keep_sel;
   logic [15:0] retry_cnt;
   logic [15:0] poll_cnt;
   logic [15:0] data_cnt;
   logic        timeout_flag;
   logic [7:0]  r1_held;

   rsp_type slot_results_due[$];
   int      errors = 0;

   assign fail_count = errors;

   function automatic logic [16:0] floor_one(logic [15:0] v);
      return (v == 16'd0) ? 17'd1 : {1'b0, v};
   endfunction

   function automatic void issue_command(logic [7:0] cmd, logic [31:0] arg, logic keep);
      cmd_byte  = cmd;
      cmd_arg   = arg;
      keep_sel  = keep;
      frame_pos = 4'd0;
      seq_phase = PH_FRAME;
   endfunction

   // End of a command's tail: retry, chain to the next init command, or finish.
   function automatic logic [1:0] command_finished();
      logic ok;
      if (cmd_byte == CMD_READ_SINGLE) begin
         seq_phase = PH_TOKEN;
         poll_cnt  = 16'd0;
         return STATUS_BUSY;
      end
      ok = (cmd_byte == CMD_GO_IDLE) ? (r1_held == R1_IDLE_STATE) : (r1_held == R1_READY);
      retry_cnt = retry_cnt + 16'd1;
      if (!ok && {1'b0, retry_cnt} < floor_one(retry_lim)) begin
         issue_command(cmd_byte, cmd_arg, 1'b0);
         return STATUS_BUSY;
      end
      if (!ok)
         timeout_flag = 1'b1;
      retry_cnt = 16'd0;
      if (cmd_byte == CMD_GO_IDLE) begin
         issue_command(CMD_SEND_OP, 32'd0, 1'b0);
         return STATUS_BUSY;
      end
      if (cmd_byte == CMD_SEND_OP) begin
         issue_command(CMD_SET_BLOCKLEN, 32'(BLOCK_BYTES), 1'b0);
         return STATUS_BUSY;
      end
      seq_phase = PH_IDLE;
      return STATUS_INIT_DONE;
   endfunction

   function automatic rsp_type next_slot_result(logic [1:0] kind, logic [22:0] sector,
                                                logic [7:0] miso);
      rsp_type    r;
      logic [1:0] done;
      r    = '0;
      done = STATUS_BUSY;
      if (seq_phase == PH_IDLE) begin
         if (kind == KIND_START_INIT) begin
            timeout_flag = 1'b0;
            retry_cnt    = 16'd0;
            poll_cnt     = 16'd0;
            seq_phase    = PH_CLOCKS;
         end else if (kind == KIND_START_READ) begin
            timeout_flag = 1'b0;
            retry_cnt    = 16'd0;
            issue_command(CMD_READ_SINGLE, 32'(sector) * 32'(BLOCK_BYTES), 1'b1);
         end
      end else if (kind == KIND_SLOT_DONE) begin
         case (seq_phase)
            PH_CLOCKS: begin
               poll_cnt = poll_cnt + 16'd1;
               if ({1'b0, poll_cnt} >= floor_one({8'd0, idle_clk_bytes})) begin
                  retry_cnt = 16'd0;
                  issue_command(CMD_GO_IDLE, 32'd0, 1'b0);
               end
            end
            PH_FRAME: begin
               frame_pos = frame_pos + 4'd1;
               if (frame_pos >= 4'd9) begin
                  seq_phase = PH_R1;
                  poll_cnt  = 16'd0;
               end
            end
            PH_R1: begin
               r1_held  = miso;
               poll_cnt = poll_cnt + 16'd1;
               if (!miso[7]) begin
                  seq_phase = PH_TAIL;
                  frame_pos = 4'd0;
               end else if ({1'b0, poll_cnt} >= floor_one({8'd0, resp_poll_lim})) begin
                  timeout_flag = 1'b1;
                  seq_phase    = PH_TAIL;
                  frame_pos    = 4'd0;
               end
            end
            PH_TAIL: begin
               frame_pos = frame_pos + 4'd1;
               if ((keep_sel && frame_pos >= 4'd1) || frame_pos >= 4'd4)
                  done = command_finished();
            end
            PH_TOKEN: begin
               poll_cnt = poll_cnt + 16'd1;
               if (miso == TOKEN_START) begin
                  seq_phase = PH_DATA;
                  data_cnt  = 16'd0;
               end else if ({1'b0, poll_cnt} >= floor_one(token_poll_lim)) begin
                  timeout_flag = 1'b1;
                  seq_phase    = PH_DATA;
                  data_cnt     = 16'd0;
               end
            end
            PH_DATA: begin
               r.read_valid = 1'b1;
               r.read_byte  = miso;
               data_cnt     = data_cnt + 16'd1;
               if (data_cnt >= 16'(BLOCK_BYTES)) begin
                  seq_phase = PH_TRAILER;
                  frame_pos = 4'd0;
               end
            end
            PH_TRAILER: begin
               frame_pos = frame_pos + 4'd1;
               if (frame_pos >= 4'd6) begin
                  seq_phase = PH_IDLE;
                  done      = STATUS_READ_DONE;
               end
            end
            default: seq_phase = PH_IDLE;
         endcase
      end

      if (seq_phase == PH_IDLE) begin
         r.slot_request  = 1'b0;
         r.mosi_byte     = BYTE_IDLE;
         r.card_deselect = 1'b1;
         r.status        = (done != STATUS_BUSY) ? done : STATUS_IDLE;
      end else begin
         r.slot_request  = 1'b1;
         r.mosi_byte     = BYTE_IDLE;
         r.card_deselect = 1'b0;
         r.status        = STATUS_BUSY;
         case (seq_phase)
            PH_CLOCKS: r.card_deselect = 1'b1;
            PH_FRAME: begin
               if (frame_pos == 4'd3)
                  r.mosi_byte = cmd_byte;
               else if (frame_pos >= 4'd4 && frame_pos <= 4'd7)
                  r.mosi_byte = cmd_arg[(7 - frame_pos) * 8 +: 8];
               else if (frame_pos == 4'd8)
                  r.mosi_byte = (cmd_byte == CMD_GO_IDLE) ? CRC_GO_IDLE :
                                (cmd_byte == CMD_SEND_OP) ? CRC_SEND_OP : BYTE_IDLE;
            end
            PH_TAIL:    r.card_deselect = (frame_pos >= 4'd1);
            PH_TRAILER: r.card_deselect = (frame_pos >= 4'd3);
            default: ;
         endcase
      end
      r.timed_out     = timeout_flag;
      r.last_response = r1_held;
      return r;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf("slot=%0b mosi=%02h desel=%0b rd_v=%0b rd=%02h status=%0d to=%0b r1=%02h",
                       r.slot_request, r.mosi_byte, r.card_deselect, r.read_valid,
                       r.read_byte, r.status, r.timed_out, r.last_response);
   endfunction

   always @(posedge clock) begin : watch_ports
      rsp_type got;
      rsp_type want;
      if (reset) begin
         resp_poll_lim  = 8'd8;
         retry_lim      = 16'hFFFF;
         token_poll_lim = 16'hFFFF;
         idle_clk_bytes = 8'd10;
         seq_phase      = PH_IDLE;
         frame_pos      = 4'd0;
         cmd_byte       = 8'd0;
         cmd_arg        = 32'd0;
         keep_sel       = 1'b0;
         retry_cnt      = 16'd0;
         poll_cnt       = 16'd0;
         data_cnt       = 16'd0;
         timeout_flag   = 1'b0;
         r1_held        = BYTE_IDLE;
         slot_results_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_RESPONSE_POLL_LIMIT: resp_poll_lim  = csr_data[7:0];
               REG_COMMAND_RETRY_LIMIT: retry_lim      = csr_data;
               REG_TOKEN_POLL_LIMIT:    token_poll_lim = csr_data;
               REG_IDLE_CLOCK_BYTES:    idle_clk_bytes = csr_data[7:0];
               default: ;
            endcase
         end
         // result side first, so a result never pairs with this edge's request
         if (rsp_valid && !rsp_stall) begin
            got.slot_request  = rsp_slot_request;
            got.mosi_byte     = rsp_mosi_byte;
            got.card_deselect = rsp_card_deselect;
            got.read_valid    = rsp_read_valid;
            got.read_byte     = rsp_read_byte;
            got.status        = rsp_status;
            got.timed_out     = rsp_timed_out;
            got.last_response = rsp_last_response;
            if (slot_results_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result: %s", $time, show(got));
            end else begin
               want = slot_results_due.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch\n  expected %s\n  actual   %s",
                              $time, show(want), show(got));
               end
            end
         end
         if (req_valid && !req_stall)
            slot_results_due.push_back(next_slot_result(req_kind, req_sector, req_miso_byte));
      end
      pending_count <= slot_results_due.size();
   end

endmodule

@@ tb/sv/tb_sd_spi_init_and_block_read.sv @@
`timescale 1ns / 1ps
// Top of the SPI-mode SD sequencer testbench: clock, reset, card-like
// stimulus and verdict. Uses sdspi_pkg, sd_spi_init_and_block_read, sdspi_slot_checker.
module tb_sd_spi_init_and_block_read;
   import sdspi_pkg::*;

   // the one request kind the package leaves unnamed
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 64;
   localparam int LONG_HOLD    = 64;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [22:0] req_sector;
   logic [7:0]  req_miso_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_slot_request;
   logic [7:0]  rsp_mosi_byte;
   logic        rsp_card_deselect;
   logic        rsp_read_valid;
   logic [7:0]  rsp_read_byte;
   logic [1:0]  rsp_status;
   logic        rsp_timed_out;
   logic [7:0]  rsp_last_response;

   int fail_count;
   int pending_count;

   // idling knobs: percents of cycles, and a hold length for the result side
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_cycles_req = 0;

   // sequence tracking: request index of the latest start and of the latest
   // transfer that reported a non-busy status
   int items_sent    = 0;
   int start_idx     = 0;
   int rsp_seen      = 0;
   int last_idle_idx = -1;

   sd_spi_init_and_block_read uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sector        (req_sector),
      .req_miso_byte     (req_miso_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_request  (rsp_slot_request),
      .rsp_mosi_byte     (rsp_mosi_byte),
      .rsp_card_deselect (rsp_card_deselect),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_status        (rsp_status),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_last_response (rsp_last_response)
   );

   sdspi_slot_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sector        (req_sector),
      .req_miso_byte     (req_miso_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_request  (rsp_slot_request),
      .rsp_mosi_byte     (rsp_mosi_byte),
      .rsp_card_deselect (rsp_card_deselect),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_status        (rsp_status),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_last_response (rsp_last_response),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Status watch for steering only; nonblocking so stimulus reads the
   // values from before the current edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_status != STATUS_BUSY)
            last_idle_idx <= rsp_seen;
         rsp_seen <= rsp_seen + 1;
      end
   end

   // Result side: random stall, or a counted long hold when asked for.
   initial begin
      int held;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req > 0) begin
            rsp_stall <= 1'b1;
            for (held = 1; held < hold_cycles_req; held++)
               @(posedge clock);
            hold_cycles_req = 0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Card-like MISO: mostly idle bytes, R1 codes and the data token, so
   // init retries and read token waits both finish in reasonable time.
   function automatic logic [7:0] card_byte();
      int r;
      r = $urandom_range(99);
      if (r < 35) return BYTE_IDLE;
      if (r < 55) return R1_IDLE_STATE;
      if (r < 75) return R1_READY;
      if (r < 85) return TOKEN_START;
      return 8'($urandom);
   endfunction

   function automatic logic [22:0] pick_sector();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return 23'($urandom);
      endcase
   endfunction

   // true once the sequence begun by the latest start has reported non-busy
   function automatic bit sequence_over();
      return last_idle_idx >= start_idx;
   endfunction

   // One request transfer; random idle cycles ahead of it.
   task automatic send_item(logic [1:0] kind, logic [22:0] sector, logic [7:0] miso);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (kind == KIND_START_INIT || kind == KIND_START_READ)
         start_idx = items_sent;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_sector    <= sector;
      req_miso_byte <= miso;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Sender stops until every expected result has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Keep answering slots until the current sequence is done, then stop
   // sending, wait for every result to come back and idle the channel.
   task automatic finish_sequence();
      while (!sequence_over())
         send_item(KIND_SLOT_DONE, pick_sector(), card_byte());
      wait_results_drained();
      repeat (4) @(posedge clock);
   endtask

   // All four limits; 8-bit registers get random upper data bits.
   task automatic write_limits(logic [7:0] rpl, logic [15:0] crl, logic [15:0] tpl,
                               logic [7:0] icb);
      csr_wr_en <= 1'b1;
      csr_index <= REG_RESPONSE_POLL_LIMIT;
      csr_data  <= {8'($urandom), rpl};
      @(posedge clock);
      csr_index <= REG_COMMAND_RETRY_LIMIT;
      csr_data  <= crl;
      @(posedge clock);
      csr_index <= REG_TOKEN_POLL_LIMIT;
      csr_data  <= tpl;
      @(posedge clock);
      csr_index <= REG_IDLE_CLOCK_BYTES;
      csr_data  <= {8'($urandom), icb};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random traffic: slot answers with card bytes, a new start once the
   // running sequence ends, plus starts while busy and the unused kind.
   // Only items that the sequencer acts on are counted.
   task automatic run_random(int n);
      int counted;
      int r;
      counted = 0;
      while (counted < n) begin
         if (sequence_over()) begin
            send_item($urandom_range(1) ? KIND_START_READ : KIND_START_INIT,
                      pick_sector(), card_byte());
            counted++;
         end else begin
            r = $urandom_range(99);
            if (r < 3)
               send_item(r[0] ? KIND_START_READ : KIND_START_INIT, pick_sector(),
                         8'($urandom));
            else if (r < 5)
               send_item(KIND_UNUSED, pick_sector(), 8'($urandom));
            else begin
               send_item(KIND_SLOT_DONE, pick_sector(), card_byte());
               counted++;
            end
         end
      end
   endtask

   initial begin
      logic [7:0] after_frame[9];
      int p;
      int i;

      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= REG_RESPONSE_POLL_LIMIT;
      csr_data      <= 16'd0;
      req_valid     <= 1'b0;
      req_kind      <= KIND_SLOT_DONE;
      req_sector    <= '0;
      req_miso_byte <= BYTE_IDLE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored items while idle, a read of the top sector,
      // starts and the unused kind while busy, then the CMD17 frame, an R1
      // poll with bit 7 set then clear, token wait and first data bytes.
      send_item(KIND_SLOT_DONE, '0, 8'h00);
      send_item(KIND_UNUSED, '0, 8'h00);
      send_item(KIND_START_READ, '1, 8'h00);
      send_item(KIND_START_INIT, '0, 8'h00);
      send_item(KIND_START_READ, '0, 8'h00);
      send_item(KIND_UNUSED, '1, BYTE_IDLE);
      for (i = 0; i < 9; i++)
         send_item(KIND_SLOT_DONE, '1, BYTE_IDLE);
      after_frame = '{8'h80, 8'h7F, BYTE_IDLE, 8'h00, TOKEN_START,
                      8'h00, BYTE_IDLE, 8'hA5, 8'h5A};
      foreach (after_frame[k])
         send_item(KIND_SLOT_DONE, '0, after_frame[k]);
      finish_sequence();

      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         // phase 0 runs on the reset limits
         case (p)
            1: write_limits(8'd1, 16'd1, 16'd1, 8'd1);
            2: write_limits(8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
            3: write_limits(8'd0, 16'd0, 16'd0, 8'd0);          // zero acts as one
            4: write_limits(8'($urandom_range(255, 1)), 16'($urandom_range(65535, 1)),
                            16'($urandom_range(65535, 1)), 8'($urandom_range(255, 1)));
            5: write_limits(8'd2, 16'd3, 16'd2, 8'd3);
            6: write_limits(8'd8, 16'hFFFF, 16'hFFFF, 8'd10);
            default: ;
         endcase
         run_random(PHASE_ITEMS / 2);
         wait_results_drained();
         // long receiver hold with the sender pushing: pipeline fills
         if (p == 0)
            hold_cycles_req = LONG_HOLD;
         run_random(PHASE_ITEMS / 2);
         wait_results_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
